// File: design/sipq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_pkg
// Types, constants and status codes for the sorted insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);
  localparam int OCC_WIDTH = 7;
  localparam int ST_WIDTH  = 2;

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_WIDTH-1:0]        cnt_t;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [ST_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [ST_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_WIDTH-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic opcode;
    key_t key_in;
  } in_item_t;

  typedef struct packed {
    key_t                 key_out;
    logic [ST_WIDTH-1:0]  status;
    logic [OCC_WIDTH-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic enq;
    logic deq;
    logic order_mode;
    key_t key;
    cnt_t count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/sipq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted store: compares the broadcast key with its own entry,
// shifts toward the back on insert and toward the front on removal.
// ----------------------------------------------------------------------------
module sipq_cell #(
  parameter int INDEX = 0
) (
  input  wire                    clk,
  input  sipq_pkg::cell_ctrl_t   ctrl,
  input  sipq_pkg::key_t         left_key,
  input  wire                    left_pass,
  input  sipq_pkg::key_t         right_key,
  input  wire                    right_pass,
  output sipq_pkg::key_t         key,
  output logic                   pass
);

  logic occupied;
  logic ahead;
  logic writable;

  assign occupied = sipq_pkg::CNT_WIDTH'(INDEX) < ctrl.count;
  assign writable = sipq_pkg::CNT_WIDTH'(INDEX) <= ctrl.count;
  assign ahead    = ctrl.order_mode ? (ctrl.key > key) : (ctrl.key < key);
  // new key moves past this entry and every entry behind it
  assign pass     = (!occupied || ahead) && right_pass;

  always_ff @(posedge clk) begin
    if (ctrl.enq && pass && writable) begin
      key <= left_pass ? left_key : ctrl.key;
    end else if (ctrl.deq) begin
      key <= right_key;
    end
  end

endmodule
`default_nettype wire

// File: design/sorted_insert_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Priority queue of signed keys kept in a row of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low; busy is never raised, so one enqueue or dequeue is taken every cycle.
//   cmd.opcode selects enqueue of cmd.key_in or dequeue of the front key.
//   Every command gives one result transaction: done is high for exactly one
//   cycle, the cycle after the command, with result.key_out, result.status
//   and result.occupancy. Throughput is one command per cycle; all cells
//   compare against the new key in parallel in the cycle of the command.
//   Equal keys leave in arrival order. A full queue rejects an enqueue and an
//   empty queue answers a dequeue with key 0 and an empty status.
//   cfg_we writes cfg_wdata into order_mode (0 min queue, 1 max queue); write
//   it only while no result is pending. Stored keys are not re-sorted.
//   Reset empties the queue and clears order_mode; no clearing pass is needed.
//   The receiver cannot stall: a result is gone after its done cycle.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  sipq_pkg::in_item_t   cmd,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  output logic                 done,
  output sipq_pkg::out_item_t  result
);

  localparam int D = sipq_pkg::DEPTH;

  logic                 order_mode;
  sipq_pkg::cnt_t       count;
  sipq_pkg::cnt_t       count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  sipq_pkg::cell_ctrl_t ctrl;
  sipq_pkg::out_item_t  result_next;

  sipq_pkg::key_t cell_key [D];
  logic           cell_pass[D];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count == sipq_pkg::CNT_WIDTH'(D);
  assign empty  = count == '0;

  always_comb begin
    ctrl.enq        = accept && (cmd.opcode == sipq_pkg::OP_ENQ) && !full;
    ctrl.deq        = accept && (cmd.opcode == sipq_pkg::OP_DEQ) && !empty;
    ctrl.order_mode = order_mode;
    ctrl.key        = cmd.key_in;
    ctrl.count      = count;
  end

  always_comb begin
    count_next         = count;
    result_next.key_out = '0;
    result_next.status  = sipq_pkg::ST_OK;
    if (cmd.opcode == sipq_pkg::OP_ENQ) begin
      if (full) begin
        result_next.status = sipq_pkg::ST_FULL;
      end else begin
        count_next = count + sipq_pkg::CNT_WIDTH'(1);
      end
    end else begin
      if (empty) begin
        result_next.status = sipq_pkg::ST_EMPTY;
      end else begin
        count_next          = count - sipq_pkg::CNT_WIDTH'(1);
        result_next.key_out = cell_key[0];
      end
    end
    result_next.occupancy = sipq_pkg::OCC_WIDTH'(count_next);
  end

  genvar i;
  generate
    for (i = 0; i < D; i++) begin : g_cell
      sipq_pkg::key_t lk;
      sipq_pkg::key_t rk;
      logic           lp;
      logic           rp;
      if (i == 0) begin : g_first
        assign lk = '0;
        assign lp = 1'b0;
      end else begin : g_mid_l
        assign lk = cell_key[i-1];
        assign lp = cell_pass[i-1];
      end
      if (i == D - 1) begin : g_last
        assign rk = '0;
        assign rp = 1'b1;
      end else begin : g_mid_r
        assign rk = cell_key[i+1];
        assign rp = cell_pass[i+1];
      end
      sipq_cell #(.INDEX(i)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .left_key   (lk),
        .left_pass  (lp),
        .right_key  (rk),
        .right_pass (rp),
        .key        (cell_key[i]),
        .pass       (cell_pass[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_mode <= cfg_wdata;
      end
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without a command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sipq_pkg::CNT_WIDTH'(D))
    else $error("key count beyond depth");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    done && result.status == sipq_pkg::ST_FULL
      |-> result.occupancy == sipq_pkg::OCC_WIDTH'(D))
    else $error("full status with room left");

  a_empty_key: assert property (@(posedge clk) disable iff (rst)
    done && result.status == sipq_pkg::ST_EMPTY
      |-> result.occupancy == '0 && result.key_out == '0)
    else $error("empty status with keys stored");

  a_occ_tracks: assert property (@(posedge clk) disable iff (rst)
    done |-> result.occupancy == sipq_pkg::OCC_WIDTH'(count))
    else $error("occupancy differs from key count");

endmodule
`default_nettype wire

// File: sim/sipq_checker.sv
// ----------------------------------------------------------------------------
// sipq_checker
// Watches the command and result channels of the priority queue, keeps its
// own sorted store to predict each result transaction, and counts mismatches.
// ----------------------------------------------------------------------------
module sipq_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 busy,
  input  sipq_pkg::in_item_t  cmd,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata,
  input  wire                 done,
  input  sipq_pkg::out_item_t result,
  output int                  error_count,
  output int                  awaited_count
);
  import sipq_pkg::*;

  key_t      model_keys [DEPTH];
  int        model_count;
  logic      model_max_first;
  out_item_t awaited_results [$];
  out_item_t oldest;

  initial begin
    error_count = 0;
    awaited_count = 0;
    model_count = 0;
    model_max_first = 1'b0;
  end

  function automatic bit leaves_first(input key_t a, input key_t b);
    return model_max_first ? (a > b) : (a < b);
  endfunction

  function automatic out_item_t model_queue_op(input in_item_t c);
    out_item_t r;
    int        pos;
    int        i;
    r.key_out = '0;
    r.status = ST_OK;
    if (c.opcode == OP_ENQ) begin
      if (model_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = model_count;
        while (pos > 0 && leaves_first(c.key_in, model_keys[pos-1])) begin
          model_keys[pos] = model_keys[pos-1];
          pos--;
        end
        model_keys[pos] = c.key_in;
        model_count++;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.key_out = model_keys[0];
      for (i = 1; i < model_count; i++) model_keys[i-1] = model_keys[i];
      model_count--;
    end
    r.occupancy = OCC_WIDTH'(model_count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      awaited_results.delete();
      model_count = 0;
      model_max_first = 1'b0;
    end else begin
      if (cfg_we) model_max_first = cfg_wdata;
      if (start && !busy) awaited_results.push_back(model_queue_op(cmd));
      if (done) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result transaction, expected none, actual %p",
                   $time, result);
        end else begin
          oldest = awaited_results.pop_front();
          if (result.key_out !== oldest.key_out) begin
            error_count++;
            $display("%0t: key_out expected %0d, actual %0d",
                     $time, oldest.key_out, result.key_out);
          end
          if (result.status !== oldest.status) begin
            error_count++;
            $display("%0t: status expected %0d, actual %0d",
                     $time, oldest.status, result.status);
          end
          if (result.occupancy !== oldest.occupancy) begin
            error_count++;
            $display("%0t: occupancy expected %0d, actual %0d",
                     $time, oldest.occupancy, result.occupancy);
          end
        end
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives enqueue and dequeue transactions into the priority queue in min and
// max order, through empty and full, with random gaps; the checker predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module testbench;
  import sipq_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  in_item_t  cmd = '0;
  logic      busy;
  logic      done;
  out_item_t result;
  int        error_count;
  int        awaited_count;
  bit        calm = 1'b0;
  int        enq_pct;

  always #1 clk = ~clk;

  sorted_insert_priority_queue uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .result    (result)
  );

  sipq_checker monitor_chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .result        (result),
    .error_count   (error_count),
    .awaited_count (awaited_count)
  );

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0: return key_t'(32'h7fff_ffff);
      1: return key_t'(32'h8000_0000);
      2: return '0;
      3: return -1;
      4, 5: return key_t'($urandom_range(0, 6)) - 3;
      default: return key_t'($urandom());
    endcase
  endfunction

  task automatic send(input logic op, input key_t key);
    @(negedge clk);
    start <= 1'b1;
    cmd <= '{opcode: op, key_in: key};
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (calm || r < 70) n = 0;
    else if (r < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic set_order(input logic v);
    @(negedge clk);
    start <= 1'b0;
    wait (awaited_count == 0);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #500000;
    $display("sorted_insert_priority_queue: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // min order: empty dequeue, extremes, ties
    send(OP_DEQ, key_t'($urandom()));
    send(OP_ENQ, key_t'(32'h7fff_ffff));
    send(OP_ENQ, key_t'(32'h8000_0000));
    send(OP_ENQ, 0);
    send(OP_ENQ, -1);
    send(OP_ENQ, 1);
    send(OP_ENQ, 5);
    send(OP_ENQ, 5);
    repeat (8) send(OP_DEQ, key_t'($urandom()));

    // max order, then switch back with keys still stored
    set_order(1'b1);
    send(OP_ENQ, key_t'(32'h8000_0000));
    send(OP_ENQ, key_t'(32'h7fff_ffff));
    send(OP_ENQ, 3);
    send(OP_ENQ, 3);
    send(OP_ENQ, -7);
    send(OP_DEQ, key_t'($urandom()));
    send(OP_DEQ, key_t'($urandom()));
    set_order(1'b0);
    send(OP_ENQ, 2);
    repeat (4) send(OP_DEQ, key_t'($urandom()));

    for (int phase = 0; phase < 10; phase++) begin
      set_order(1'($urandom_range(0, 1)));
      case (phase % 4)
        0, 1: enq_pct = 95;
        2: enq_pct = 50;
        default: enq_pct = 15;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        idle_gap();
        if ($urandom_range(1, 100) <= enq_pct) send(OP_ENQ, pick_key());
        else send(OP_DEQ, key_t'($urandom()));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (awaited_count == 0);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_insert_priority_queue: match");
    end else begin
      $display("sorted_insert_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sipq_pkg.sv
design/sipq_cell.sv
design/sorted_insert_priority_queue.sv
sim/sipq_checker.sv
sim/testbench.sv
